@@ src/lvf_pkg.sv @@
// Package for the linear volume fader: widths, limits, opcode and state enums,
// and the command/status structs between controller and datapath.
// No dependencies.
package lvf_pkg;

	localparam int VOL_W   = 7;
	localparam int DUR_W   = 16;
	localparam int TICK_W  = 10;
	// Tick numerator stays below 201 * (2**DUR_W - 1), which fits in 24 bits.
	localparam int NUM_W   = 24;
	localparam int DVS_W   = DUR_W + 1;
	localparam int CNT_W   = $clog2(NUM_W + 1);

	localparam logic [VOL_W-1:0]  MAX_VOLUME = 7'd100;
	localparam logic [TICK_W-1:0] TICK_RESET = 10'd20;

	typedef enum logic [1:0] {
		OP_FADE    = 2'd0,
		OP_FADE_IN = 2'd1,
		OP_TICK    = 2'd2,
		OP_STOP    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_LOAD,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load_item;
		logic div_dur;
		logic mul;
		logic div_tick;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_dur_div;
		logic need_tick_div;
		logic div_done;
	} dp_status_t;

endpackage

@@ src/lvf_cmd_if.sv @@
// Command channel of the volume fader: valid/ready plus the command payload.
// Depends on lvf_pkg.
interface lvf_cmd_if;
	logic                        valid;
	logic                        ready;
	lvf_pkg::op_t                op;
	logic [lvf_pkg::VOL_W-1:0]   target_volume;
	logic [lvf_pkg::DUR_W-1:0]   duration_ms;

	modport source (output valid, op, target_volume, duration_ms, input ready);
	modport sink   (input valid, op, target_volume, duration_ms, output ready);
endinterface

@@ src/lvf_rsp_if.sv @@
// Result channel of the volume fader: valid/ready plus the result payload.
// Depends on lvf_pkg.
interface lvf_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [lvf_pkg::VOL_W-1:0] volume;
	logic                      volume_written;
	logic                      fade_started;
	logic                      fade_progress;
	logic                      fade_finished;
	logic                      fading;

	modport source (output valid, volume, volume_written, fade_started, fade_progress,
		fade_finished, fading, input ready);
	modport sink   (input valid, volume, volume_written, fade_started, fade_progress,
		fade_finished, fading, output ready);
endinterface

@@ src/lvf_div.sv @@
// Restoring serial divider, one quotient bit per cycle, shared by the step
// count and the tick volume computations. Depends on lvf_pkg.
module lvf_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lvf_pkg::NUM_W-1:0]   dividend,
	input  logic [lvf_pkg::DVS_W-1:0]   divisor,
	output logic [lvf_pkg::NUM_W-1:0]   quotient,
	output logic                        done
);
	localparam int NW = lvf_pkg::NUM_W;
	localparam int DW = lvf_pkg::DVS_W;
	localparam int CW = lvf_pkg::CNT_W;

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] acc_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvs_q;

	logic [DW:0]   shifted;
	logic [DW+1:0] diff;
	logic          fits;

	assign shifted = {rem_q, acc_q[NW-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
	assign fits    = ~diff[DW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The dividend shifts out at the top while quotient bits shift in below.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			acc_q <= {acc_q[NW-2:0], fits};
			rem_q <= fits ? diff[DW-1:0] : shifted[DW-1:0];
		end
	end

	assign quotient = acc_q;
	assign done     = done_q;
endmodule

@@ src/lvf_dp.sv @@
// Datapath of the volume fader: item and fade state registers, tick interval
// register, multipliers, divider and result register. Depends on lvf_pkg, lvf_div.
module lvf_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lvf_pkg::TICK_W-1:0]    cfg_wdata,
	input  lvf_pkg::op_t                  op_in,
	input  logic [lvf_pkg::VOL_W-1:0]     target_in,
	input  logic [lvf_pkg::DUR_W-1:0]     duration_in,
	input  lvf_pkg::ctrl_cmd_t            cmd,
	output lvf_pkg::dp_status_t           status,
	output logic [lvf_pkg::VOL_W-1:0]     volume,
	output logic                          volume_written,
	output logic                          fade_started,
	output logic                          fade_progress,
	output logic                          fade_finished,
	output logic                          fading
);
	localparam int VW = lvf_pkg::VOL_W;
	localparam int DW = lvf_pkg::DUR_W;
	localparam int TW = lvf_pkg::TICK_W;
	localparam int NW = lvf_pkg::NUM_W;
	localparam int SW = lvf_pkg::DVS_W;

	// Configuration and fade state.
	logic [TW-1:0] tick_q;
	logic          fading_q;
	logic [VW-1:0] cur_q;
	logic [VW-1:0] start_q;
	logic [VW-1:0] goal_q;
	logic [DW-1:0] done_q;
	logic [DW-1:0] total_q;

	// Item being worked on.
	lvf_pkg::op_t  op_q;
	logic [VW-1:0] tgt_q;
	logic [DW-1:0] dur_q;

	// Products for the tick volume.
	logic signed [VW+DW+1:0] prod_rk_q;
	logic [VW+DW-1:0]        prod_sn_q;

	// Result register.
	logic [VW-1:0] res_vol_q;
	logic          res_wr_q, res_start_q, res_prog_q, res_fin_q, res_fading_q;

	logic [TW-1:0]           tick_eff;
	logic [VW-1:0]           eff_cur;
	logic [DW-1:0]           k;
	logic                    begins;
	logic                    tick_live;
	logic                    tick_mid;
	logic signed [VW:0]      range_s;
	logic signed [NW+2:0]    num_full;
	logic                    div_start;
	logic [NW-1:0]           div_dvd;
	logic [SW-1:0]           div_dvs;
	logic [NW-1:0]           quo;
	logic                    div_done;
	logic [VW-1:0]           tick_vol;
	logic                    end_now;

	logic [VW-1:0] n_cur, n_start, n_goal;
	logic [DW-1:0] n_done, n_total;
	logic          n_fading;
	logic          wr, started, progress, finished;

	assign tick_eff  = (tick_q == '0) ? TW'(1) : tick_q;
	assign eff_cur   = (op_q == lvf_pkg::OP_FADE_IN) ? '0 : cur_q;
	assign k         = done_q + 1'b1;
	assign begins    = (op_q == lvf_pkg::OP_FADE || op_q == lvf_pkg::OP_FADE_IN)
		&& (dur_q != '0) && (eff_cur != tgt_q);
	assign tick_live = (op_q == lvf_pkg::OP_TICK) && fading_q;
	assign tick_mid  = tick_live && (k < total_q);
	assign range_s   = $signed({1'b0, goal_q}) - $signed({1'b0, start_q});

	// 2*s*n + 2*range*k + n, always positive while the fade is in progress.
	assign num_full = $signed({3'b000, prod_sn_q, 1'b0})
		+ $signed({prod_rk_q[VW+DW+1], prod_rk_q, 1'b0})
		+ $signed({{(NW+3-DW){1'b0}}, total_q});

	assign div_start = cmd.div_dur | cmd.div_tick;
	assign div_dvd   = cmd.div_tick ? num_full[NW-1:0] : {{(NW-DW){1'b0}}, dur_q};
	assign div_dvs   = cmd.div_tick ? {total_q, 1'b0} : {{(SW-TW){1'b0}}, tick_eff};

	lvf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.quotient (quo),
		.done     (div_done)
	);

	assign status.need_dur_div  = begins;
	assign status.need_tick_div = tick_mid;
	assign status.div_done      = div_done;

	assign tick_vol = tick_mid ? quo[VW-1:0] : goal_q;
	assign end_now  = !tick_mid || (goal_q > start_q && tick_vol >= goal_q)
		|| (goal_q < start_q && tick_vol <= goal_q);

	always_comb begin
		n_cur    = cur_q;
		n_start  = start_q;
		n_goal   = goal_q;
		n_done   = done_q;
		n_total  = total_q;
		n_fading = fading_q;
		wr       = 1'b0;
		started  = 1'b0;
		progress = 1'b0;
		finished = 1'b0;
		unique case (op_q)
			lvf_pkg::OP_FADE, lvf_pkg::OP_FADE_IN: begin
				if (op_q == lvf_pkg::OP_FADE_IN) begin
					n_cur    = '0;
					wr       = 1'b1;
					progress = 1'b1;
				end
				if (dur_q == '0) begin
					n_cur = tgt_q;
					wr    = 1'b1;
				end else if (begins) begin
					started  = !fading_q;
					n_fading = 1'b1;
					n_start  = eff_cur;
					n_goal   = tgt_q;
					n_done   = '0;
					n_total  = quo[DW-1:0];
				end
			end
			lvf_pkg::OP_TICK: begin
				if (tick_live) begin
					wr     = 1'b1;
					n_done = k;
					if (end_now) begin
						n_cur    = goal_q;
						n_fading = 1'b0;
						finished = 1'b1;
					end else begin
						n_cur    = tick_vol;
						progress = 1'b1;
					end
				end
			end
			lvf_pkg::OP_STOP: begin
				if (fading_q) begin
					n_fading = 1'b0;
					finished = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q   <= lvf_pkg::TICK_RESET;
			fading_q <= 1'b0;
			cur_q    <= '0;
			start_q  <= '0;
			goal_q   <= '0;
			done_q   <= '0;
			total_q  <= '0;
		end else begin
			if (cfg_we)
				tick_q <= cfg_wdata;
			if (cmd.commit) begin
				fading_q <= n_fading;
				cur_q    <= n_cur;
				start_q  <= n_start;
				goal_q   <= n_goal;
				done_q   <= n_done;
				total_q  <= n_total;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q  <= op_in;
			tgt_q <= (target_in > lvf_pkg::MAX_VOLUME) ? lvf_pkg::MAX_VOLUME : target_in;
			dur_q <= duration_in;
		end
		if (cmd.mul) begin
			prod_rk_q <= $signed({{(DW+1){range_s[VW]}}, range_s})
				* $signed({{(VW+2){1'b0}}, k});
			prod_sn_q <= {{DW{1'b0}}, start_q} * {{VW{1'b0}}, total_q};
		end
		if (cmd.commit) begin
			res_vol_q    <= n_cur;
			res_wr_q     <= wr;
			res_start_q  <= started;
			res_prog_q   <= progress;
			res_fin_q    <= finished;
			res_fading_q <= n_fading;
		end
	end

	assign volume         = res_vol_q;
	assign volume_written = res_wr_q;
	assign fade_started   = res_start_q;
	assign fade_progress  = res_prog_q;
	assign fade_finished  = res_fin_q;
	assign fading         = res_fading_q;
endmodule

@@ src/lvf_ctrl.sv @@
// Controller of the volume fader: sequences each command through the datapath
// and owns the handshake flags of both channels. Depends on lvf_pkg.
module lvf_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	input  lvf_pkg::dp_status_t   status,
	output lvf_pkg::ctrl_cmd_t    cmd
);
	lvf_pkg::state_t state_q, state_d;
	logic            out_valid_q;
	logic            out_free;

	assign out_free = !out_valid_q || rsp_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lvf_pkg::ST_IDLE: if (cmd_valid) state_d = lvf_pkg::ST_EVAL;
			lvf_pkg::ST_EVAL: begin
				priority if (status.need_dur_div) state_d = lvf_pkg::ST_DIV;
				else if (status.need_tick_div)    state_d = lvf_pkg::ST_LOAD;
				else                              state_d = lvf_pkg::ST_FIN;
			end
			lvf_pkg::ST_LOAD: state_d = lvf_pkg::ST_DIV;
			lvf_pkg::ST_DIV:  if (status.div_done) state_d = lvf_pkg::ST_FIN;
			lvf_pkg::ST_FIN:  if (out_free) state_d = lvf_pkg::ST_IDLE;
			default:          state_d = lvf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd_ready = 1'b0;
		unique case (state_q)
			lvf_pkg::ST_IDLE: begin
				cmd_ready     = 1'b1;
				cmd.load_item = cmd_valid;
			end
			lvf_pkg::ST_EVAL: begin
				cmd.div_dur = status.need_dur_div;
				cmd.mul     = !status.need_dur_div && status.need_tick_div;
			end
			lvf_pkg::ST_LOAD: cmd.div_tick = 1'b1;
			lvf_pkg::ST_DIV:  ;
			lvf_pkg::ST_FIN:  cmd.commit = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lvf_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = out_valid_q;
endmodule

@@ src/linear_volume_fader.sv @@
// Top level of the linear volume fader: controller plus datapath.
// Depends on lvf_pkg, lvf_cmd_if, lvf_rsp_if, lvf_ctrl, lvf_dp.
//
//   Channel   Kind       Direction  Contents
//   cmd       valid/rdy  in         op, target_volume, duration_ms
//   rsp       valid/rdy  out        volume and five status flags
//   cfg       write      in         tick_interval_ms (cfg_we, cfg_wdata)
//
// A command with no division (stop, idle tick, immediate set) passes through
// the idle, evaluate and finish states. A fade start runs the shared serial
// divider after evaluate, and an intermediate tick runs it after a load state.
// One command is in flight at a time; the next transfer is taken while the
// previous result still waits in the output register. Reset clears all fade
// state to zero and the tick interval to 20.
module linear_volume_fader (
	input  logic                        clk,
	input  logic                        arst_n,
	lvf_cmd_if.sink                     cmd,
	lvf_rsp_if.source                   rsp,
	input  logic                        cfg_we,
	input  logic [lvf_pkg::TICK_W-1:0]  cfg_wdata
);
	lvf_pkg::ctrl_cmd_t  ctrl_cmd;
	lvf_pkg::dp_status_t dp_status;

	lvf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.status    (dp_status),
		.cmd       (ctrl_cmd)
	);

	lvf_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.op_in          (cmd.op),
		.target_in      (cmd.target_volume),
		.duration_in    (cmd.duration_ms),
		.cmd            (ctrl_cmd),
		.status         (dp_status),
		.volume         (rsp.volume),
		.volume_written (rsp.volume_written),
		.fade_started   (rsp.fade_started),
		.fade_progress  (rsp.fade_progress),
		.fade_finished  (rsp.fade_finished),
		.fading         (rsp.fading)
	);

`ifndef SYNTH
	// Only one command is worked on at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("command taken while another is in flight");

	a_vol_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.volume <= lvf_pkg::MAX_VOLUME)
		else $error("volume above maximum");

	a_prog_fin: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.fade_progress && rsp.fade_finished))
		else $error("progress and finish reported together");

	a_start_fading: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.fade_started |-> rsp.fading && !rsp.fade_finished)
		else $error("fade started but not running");
`endif
endmodule
